[sv/assert_macros.svh]
// Assertion macros shared by the trajectory generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle brings a consequence in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ptg_pkg.sv]
// Types, constants and the sine table builder for the trajectory generator.
`default_nettype none

package ptg_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_MODE         = 3'd0;
    localparam logic [2:0] CFG_PHASE_STEP   = 3'd1;
    localparam logic [2:0] CFG_TOTAL_POINTS = 3'd2;
    localparam logic [2:0] CFG_RADIUS       = 3'd3;
    localparam logic [2:0] CFG_START_X      = 3'd4;
    localparam logic [2:0] CFG_START_Z      = 3'd5;

    // Path modes
    localparam logic [2:0] MODE_HORIZONTAL = 3'd0;
    localparam logic [2:0] MODE_VERTICAL   = 3'd1;
    localparam logic [2:0] MODE_LISSAJOUS  = 3'd2;
    localparam logic [2:0] MODE_EIGHT      = 3'd3;
    localparam logic [2:0] MODE_INCLINED   = 3'd4;

    // Register reset values
    localparam logic [2:0]         RST_MODE         = MODE_HORIZONTAL;
    localparam logic [15:0]        RST_PHASE_STEP   = 16'd33;
    localparam logic [15:0]        RST_TOTAL_POINTS = 16'd6000;
    localparam logic [14:0]        RST_RADIUS       = 15'd1966;

    // Phase constants in 16-bit turn units
    localparam logic [15:0] PHASE_PI      = 16'h8000;
    localparam logic [15:0] PHASE_QUARTER = 16'h4000;
    localparam logic [15:0] PHASE_EIGHTH  = 16'h2000;

    // cos(pi/6) in Q1.14
    localparam logic signed [15:0] COS_PI6_Q14 = 16'sd14189;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Depth of the queue between front and back end (power of two)
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    // One classified waypoint request
    typedef struct packed {
        logic [15:0] angle;
        logic [15:0] point_number;
        logic        last;
    } cmd_t;

    // Queue status seen by its neighbours
    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

    // Back end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOOK_C,
        BK_MUL_C,
        BK_LOOK_S,
        BK_MUL_S,
        BK_MUL_K,
        BK_EMIT
    } bk_state_t;

    // Taylor step: multiply by x^2 in Q30; the caller then divides by the series factor
    function automatic logic [63:0] taylor_step(input logic [63:0] t, input logic [63:0] x2);
        logic [63:0] p;
        p = (t * x2) >> 30;
        return p;
    endfunction

    // Round sin(x) of a Q30 angle to Q1.14, clamped to 0..16384
    function automatic logic [14:0] sin_q14_of(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] s;
        x2 = (x * x) >> 30;
        t  = x;
        s  = signed'(x);
        t = taylor_step(t, x2) / 64'd6;   s = s - signed'(t);
        t = taylor_step(t, x2) / 64'd20;  s = s + signed'(t);
        t = taylor_step(t, x2) / 64'd42;  s = s - signed'(t);
        t = taylor_step(t, x2) / 64'd72;  s = s + signed'(t);
        t = taylor_step(t, x2) / 64'd110; s = s - signed'(t);
        t = taylor_step(t, x2) / 64'd156; s = s + signed'(t);
        t = taylor_step(t, x2) / 64'd210; s = s - signed'(t);
        t = taylor_step(t, x2) / 64'd272; s = s + signed'(t);
        t = taylor_step(t, x2) / 64'd342; s = s - signed'(t);
        t = taylor_step(t, x2) / 64'd420; s = s + signed'(t);
        t = taylor_step(t, x2) / 64'd506; s = s - signed'(t);
        t = taylor_step(t, x2) / 64'd600; s = s + signed'(t);
        if (s < 0)
        begin
            s = '0;
        end
        s = (s + 64'sd32768) >>> 16;
        if (s > 64'sd16384)
        begin
            s = 64'sd16384;
        end
        return s[14:0];
    endfunction

endpackage

`default_nettype wire

[sv/parametric_trajectory_generator.sv]
// Top level of the parametric trajectory generator.
`default_nettype none
`include "assert_macros.svh"

// Each transfer on the input channel asks for the next waypoint of a circle,
// Lissajous, figure-eight or inclined path; restart set begins a run again at
// point zero. The front end takes one request per cycle, while the queue is not
// full, into a two-entry queue; the back end then steps through its lookup,
// multiply and emit states for each waypoint, using its single shared multiplier
// two or three times per point with a table lookup before each radius product. A finished waypoint waits in the
// output register while the next one is computed. Write registers only while
// the block is idle.
module parametric_trajectory_generator #(
    parameter int unsigned SINE_TABLE_DEPTH = 256,
    parameter int unsigned COORD_WIDTH      = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               restart,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      pos_x,
    output logic signed [15:0]      pos_y,
    output logic signed [15:0]      pos_z,
    output logic [15:0]             point_number,
    output logic                    last
);
    import ptg_pkg::*;

    logic [2:0]         mode_reg;
    logic [15:0]        phase_step_reg;
    logic [15:0]        total_points_reg;
    logic [14:0]        radius_reg;
    logic signed [15:0] start_x_reg;
    logic signed [15:0] start_z_reg;

    logic               push;
    cmd_t               q_in;
    cmd_t               q_out;
    logic               pop;
    q_status_t          q_status;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= RST_MODE;
            phase_step_reg   <= RST_PHASE_STEP;
            total_points_reg <= RST_TOTAL_POINTS;
            radius_reg       <= RST_RADIUS;
            start_x_reg      <= '0;
            start_z_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:         mode_reg         <= cfg_data[2:0];
                CFG_PHASE_STEP:   phase_step_reg   <= cfg_data;
                CFG_TOTAL_POINTS: total_points_reg <= cfg_data;
                CFG_RADIUS:       radius_reg       <= cfg_data[14:0];
                CFG_START_X:      start_x_reg      <= signed'(cfg_data);
                CFG_START_Z:      start_z_reg      <= signed'(cfg_data);
                default:          ;
            endcase
        end
    end

    ptg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .restart      (restart),
        .phase_step   (phase_step_reg),
        .total_points (total_points_reg),
        .q_status     (q_status),
        .push         (push),
        .cmd          (q_in)
    );

    ptg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .pop       (pop),
        .pop_data  (q_out),
        .status    (q_status)
    );

    ptg_back #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .COORD_WIDTH      (COORD_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .q_data       (q_out),
        .pop          (pop),
        .mode         (mode_reg),
        .radius       (radius_reg),
        .start_x      (start_x_reg),
        .start_z      (start_z_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .point_number (point_number),
        .last         (last)
    );

    // The back end only drains a queue that holds a command
    `ASSERT_CLK(a_pop_needs_entry, pop |-> q_status.not_empty, "pop from empty queue")
    // A queued command stays until the back end takes it
    `ASSERT_NEXT(a_entry_held, q_status.not_empty && !pop, q_status.not_empty, "queued command lost")
    // A restart transfer issues point zero at angle pi
    `ASSERT_CLK(a_restart_cmd, (push && restart) |-> (q_in.point_number == '0 && q_in.angle == PHASE_PI), "restart command wrong")

endmodule

`default_nettype wire

[sv/ptg_queue.sv]
// Short command queue between the front end and the back end.
`default_nettype none

module ptg_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire ptg_pkg::cmd_t      push_data,
    input  wire logic               pop,
    output ptg_pkg::cmd_t           pop_data,
    output ptg_pkg::q_status_t      status
);
    import ptg_pkg::*;

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_next;
    logic [QPTR_W:0]      count_reg;
    logic [QPTR_W:0]      count_next;

    // Report occupancy
    assign status.not_empty = (count_reg != '0);
    assign status.full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_data         = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[sv/ptg_front.sv]
// Front end: takes step requests, keeps phase and point count, issues commands.
`default_nettype none

module ptg_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               restart,
    input  wire logic [15:0]        phase_step,
    input  wire logic [15:0]        total_points,
    input  wire ptg_pkg::q_status_t q_status,
    output logic                    push,
    output ptg_pkg::cmd_t           cmd
);
    import ptg_pkg::*;

    logic [15:0] phase_acc_reg;
    logic [15:0] phase_acc_next;
    logic [15:0] point_count_reg;
    logic [15:0] point_count_next;
    logic [15:0] phase_cur;
    logic [15:0] count_cur;
    logic [16:0] count_inc;
    logic        is_last;

    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;

    // Classify the request: restart, angle and end of run
    always_comb
    begin
        phase_cur        = restart ? '0 : phase_acc_reg;
        count_cur        = restart ? '0 : point_count_reg;
        count_inc        = {1'b0, count_cur} + 17'd1;
        is_last          = (count_inc >= {1'b0, total_points});
        cmd.angle        = phase_cur + PHASE_PI;
        cmd.point_number = count_cur;
        cmd.last         = is_last;
        phase_acc_next   = is_last ? '0 : phase_cur + phase_step;
        point_count_next = is_last ? '0 : count_inc[15:0];
    end

    // Advance the run state on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg   <= '0;
            point_count_reg <= '0;
        end
        else if (push)
        begin
            phase_acc_reg   <= phase_acc_next;
            point_count_reg <= point_count_next;
        end
    end

endmodule

`default_nettype wire

[sv/ptg_back.sv]
// Back end: sine table, shared multiplier sequencer and result register.
`default_nettype none

module ptg_back #(
    parameter int unsigned SINE_TABLE_DEPTH = 256,
    parameter int unsigned COORD_WIDTH      = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ptg_pkg::q_status_t q_status,
    input  wire ptg_pkg::cmd_t      q_data,
    output logic                    pop,
    input  wire logic [2:0]         mode,
    input  wire logic [14:0]        radius,
    input  wire logic signed [15:0] start_x,
    input  wire logic signed [15:0] start_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      pos_x,
    output logic signed [15:0]      pos_y,
    output logic signed [15:0]      pos_z,
    output logic [15:0]             point_number,
    output logic                    last
);
    import ptg_pkg::*;

    localparam int unsigned IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int unsigned LK_W  = IDX_W + 15;
    localparam logic signed [47:0] SAT_HI = (48'sd1 <<< (COORD_WIDTH - 1)) - 48'sd1;
    localparam logic signed [47:0] SAT_LO = -SAT_HI - 48'sd1;

    // Quarter-wave table, built at elaboration
    logic [14:0] qtab [SINE_TABLE_DEPTH + 1];

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++)
    begin : g_qtab
        localparam logic [14:0] ENTRY =
            sin_q14_of(64'(k) * HALF_PI_Q30 / SINE_TABLE_DEPTH);
        assign qtab[k] = ENTRY;
    end

    bk_state_t              state_reg;
    bk_state_t              state_next;
    cmd_t                   cmd_reg;
    logic signed [15:0]     trig_reg;
    logic signed [29:0]     prodc_reg;
    logic signed [29:0]     prods_reg;
    logic signed [43:0]     prodk_reg;
    logic                   out_valid_reg;
    logic signed [15:0]     pos_x_reg;
    logic signed [15:0]     pos_y_reg;
    logic signed [15:0]     pos_z_reg;
    logic [15:0]            point_number_reg;
    logic                   last_reg;

    logic                   ld_trig;
    logic                   ld_prodc;
    logic                   ld_prods;
    logic                   ld_prodk;
    logic                   emit;

    logic [15:0]            look_angle;
    logic [1:0]             quad;
    logic [14:0]            qphase;
    logic [LK_W-1:0]        idx_full;
    logic [IDX_W-1:0]       idx;
    logic signed [15:0]     trig_val;

    logic signed [29:0]     mul_a;
    logic signed [15:0]     mul_b;
    logic signed [45:0]     mul_p;

    logic signed [47:0]     x_val;
    logic signed [47:0]     y_val;
    logic signed [47:0]     z_val;

    // Round half up by a right shift of sh bits
    function automatic logic signed [47:0] round_shift(
        input logic signed [47:0] v,
        input int unsigned        sh
    );
        logic signed [47:0] half;
        half = 48'sd1 <<< (sh - 1);
        return (v + half) >>> sh;
    endfunction

    // Saturate to the coordinate width and keep the output field bits
    function automatic logic signed [15:0] sat_coord(input logic signed [47:0] v);
        logic signed [47:0] s;
        s = v;
        if (v > SAT_HI)
        begin
            s = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            s = SAT_LO;
        end
        return s[15:0];
    endfunction

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:   if (q_status.not_empty) state_next = BK_LOOK_C;
            BK_LOOK_C: state_next = BK_MUL_C;
            BK_MUL_C:  state_next = BK_LOOK_S;
            BK_LOOK_S: state_next = BK_MUL_S;
            BK_MUL_S:  state_next = (mode == MODE_INCLINED) ? BK_MUL_K : BK_EMIT;
            BK_MUL_K:  state_next = BK_EMIT;
            BK_EMIT:   if (!out_valid_reg || out_ready) state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        pop      = (state_reg == BK_IDLE) && q_status.not_empty;
        ld_trig  = (state_reg == BK_LOOK_C) || (state_reg == BK_LOOK_S);
        ld_prodc = (state_reg == BK_MUL_C);
        ld_prods = (state_reg == BK_MUL_S);
        ld_prodk = (state_reg == BK_MUL_K);
        emit     = (state_reg == BK_EMIT) && (!out_valid_reg || out_ready);
    end

    // Pick the lookup angle: cosine first, then the mode's second angle
    always_comb
    begin
        if (state_reg == BK_LOOK_C)
        begin
            look_angle = cmd_reg.angle + PHASE_QUARTER;
        end
        else if (mode == MODE_LISSAJOUS)
        begin
            look_angle = cmd_reg.angle - PHASE_EIGHTH;
        end
        else if (mode == MODE_EIGHT)
        begin
            look_angle = {cmd_reg.angle[14:0], 1'b0};
        end
        else
        begin
            look_angle = cmd_reg.angle;
        end
    end

    // Fold the angle into the first quadrant and read the nearest entry
    always_comb
    begin
        quad     = look_angle[15:14];
        qphase   = quad[0] ? (15'(PHASE_QUARTER) - {1'b0, look_angle[13:0]})
                           : {1'b0, look_angle[13:0]};
        idx_full = (LK_W'(qphase) * LK_W'(SINE_TABLE_DEPTH) + LK_W'(8192)) >> 14;
        if (idx_full > LK_W'(SINE_TABLE_DEPTH))
        begin
            idx = IDX_W'(SINE_TABLE_DEPTH);
        end
        else
        begin
            idx = idx_full[IDX_W-1:0];
        end
        trig_val = quad[1] ? -signed'({1'b0, qtab[idx]}) : signed'({1'b0, qtab[idx]});
    end

    // Shared multiplier: radius times trig, or r*cos times cos(pi/6)
    always_comb
    begin
        if (state_reg == BK_MUL_K)
        begin
            mul_a = prodc_reg;
            mul_b = COS_PI6_Q14;
        end
        else
        begin
            mul_a = {{14{trig_reg[15]}}, trig_reg};
            mul_b = signed'({1'b0, radius});
        end
        mul_p = mul_a * mul_b;
    end

    // Assemble the coordinates for the current mode
    always_comb
    begin
        x_val = '0;
        y_val = '0;
        z_val = '0;
        unique case (mode)
            MODE_HORIZONTAL:
            begin
                x_val = round_shift({{18{prodc_reg[29]}}, prodc_reg}, 14);
                y_val = round_shift({{18{prods_reg[29]}}, prods_reg}, 14);
                z_val = {{32{start_z[15]}}, start_z};
            end
            MODE_VERTICAL:
            begin
                x_val = {{32{start_x[15]}}, start_x};
                y_val = round_shift({{18{prods_reg[29]}}, prods_reg}, 14);
                z_val = round_shift({{18{prodc_reg[29]}}, prodc_reg}, 14);
            end
            MODE_LISSAJOUS:
            begin
                x_val = round_shift({{18{prodc_reg[29]}}, prodc_reg}, 14);
                y_val = round_shift({{18{prods_reg[29]}}, prods_reg}, 14);
                z_val = {{32{start_z[15]}}, start_z};
            end
            MODE_EIGHT:
            begin
                x_val = round_shift({{18{prods_reg[29]}}, prods_reg}, 15);
                y_val = round_shift({{18{prodc_reg[29]}}, prodc_reg}, 14);
                z_val = {{32{start_z[15]}}, start_z};
            end
            MODE_INCLINED:
            begin
                x_val = round_shift({{4{prodk_reg[43]}}, prodk_reg}, 28);
                y_val = round_shift({{18{prods_reg[29]}}, prods_reg}, 14);
                z_val = round_shift({{18{prodc_reg[29]}}, prodc_reg}, 15);
            end
            default:
            begin
                x_val = '0;
                y_val = '0;
                z_val = '0;
            end
        endcase
    end

    // Sequencer state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= q_data;
        end
        if (ld_trig)
        begin
            trig_reg <= trig_val;
        end
        if (ld_prodc)
        begin
            prodc_reg <= mul_p[29:0];
        end
        if (ld_prods)
        begin
            prods_reg <= mul_p[29:0];
        end
        if (ld_prodk)
        begin
            prodk_reg <= mul_p[43:0];
        end
        if (emit)
        begin
            pos_x_reg        <= sat_coord(x_val);
            pos_y_reg        <= sat_coord(y_val);
            pos_z_reg        <= sat_coord(z_val);
            point_number_reg <= cmd_reg.point_number;
            last_reg         <= cmd_reg.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign pos_z        = pos_z_reg;
    assign point_number = point_number_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

[tb/waypoint_checker.sv]
// Waypoint checker: mirrors the generator's registers, predicts every point and compares.
module waypoint_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic               restart,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic signed [15:0] pos_x,
    input  wire logic signed [15:0] pos_y,
    input  wire logic signed [15:0] pos_z,
    input  wire logic [15:0]        point_number,
    input  wire logic               last,
    output int unsigned             mismatches,
    output int unsigned             waiting
);
    import ptg_pkg::*;

    localparam int unsigned TABLE_DEPTH  = 256;
    localparam int unsigned QUARTER_TURN = 16384;
    localparam int unsigned PRINT_CAP    = 60;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [15:0]        number;
        logic               end_of_run;
    } waypoint_t;

    int                 quarter_sine [0:TABLE_DEPTH];
    logic [2:0]         path_mode;
    logic [15:0]        step_size;
    logic [15:0]        run_length;
    logic [14:0]        path_radius;
    logic signed [15:0] fixed_x;
    logic signed [15:0] fixed_z;
    logic [15:0]        phase;
    logic [15:0]        count;
    waypoint_t          expected_points [$];
    int unsigned        fail_count = 0;

    // sin of a Q30 angle in the first quadrant, rounded to Q1.14 by a Taylor series
    function automatic int series_sine_q14(input logic [63:0] ang);
        logic [63:0] sq;
        logic [63:0] term;
        longint      acc;
        int unsigned k;
        sq   = (ang * ang) >> 30;
        term = ang;
        acc  = longint'(ang);
        for (k = 1; k <= 12; k++)
        begin
            term = ((term * sq) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
            if ((k % 2) == 1)
                acc -= longint'(term);
            else
                acc += longint'(term);
        end
        if (acc < 0)
            acc = 0;
        acc = (acc + 32768) / 65536;
        if (acc > 16384)
            acc = 16384;
        return int'(acc);
    endfunction

    // Nearest table entry for a position 0..QUARTER_TURN within the quadrant
    function automatic int table_value(input int unsigned p);
        int unsigned idx;
        idx = (p * TABLE_DEPTH + 8192) >> 14;
        if (idx > TABLE_DEPTH)
            idx = TABLE_DEPTH;
        return quarter_sine[idx];
    endfunction

    // Fold a 16-bit turn angle onto the quarter wave
    function automatic int sine_of_turn(input logic [15:0] ang);
        int unsigned p;
        int          v;
        p = ang[13:0];
        if (ang[14])
            v = table_value(QUARTER_TURN - p);
        else
            v = table_value(p);
        return ang[15] ? -v : v;
    endfunction

    function automatic int cosine_of_turn(input logic [15:0] ang);
        logic [15:0] shifted;
        shifted = ang + PHASE_QUARTER;
        return sine_of_turn(shifted);
    endfunction

    // Round half up, then drop sh fraction bits
    function automatic longint round_shift_q(input longint v, input int unsigned sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [15:0] clamp_coord(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // Work out the next waypoint and advance the phase and point counter
    function automatic waypoint_t next_waypoint(input logic from_start);
        waypoint_t   pt;
        logic [15:0] ang;
        logic [15:0] eighth_back;
        logic [15:0] doubled;
        longint      r;
        longint      px;
        longint      py;
        longint      pz;
        longint      rc;
        int unsigned pos;
        int unsigned span;
        if (from_start)
        begin
            phase = '0;
            count = '0;
        end
        ang         = PHASE_PI + phase;
        eighth_back = ang - PHASE_EIGHTH;
        doubled     = ang << 1;
        r  = path_radius;
        px = 0;
        py = 0;
        pz = 0;
        case (path_mode)
            MODE_HORIZONTAL:
            begin
                px = round_shift_q(r * cosine_of_turn(ang), 14);
                py = round_shift_q(r * sine_of_turn(ang), 14);
                pz = fixed_z;
            end
            MODE_VERTICAL:
            begin
                px = fixed_x;
                py = round_shift_q(r * sine_of_turn(ang), 14);
                pz = round_shift_q(r * cosine_of_turn(ang), 14);
            end
            MODE_LISSAJOUS:
            begin
                px = round_shift_q(r * cosine_of_turn(ang), 14);
                py = round_shift_q(r * sine_of_turn(eighth_back), 14);
                pz = fixed_z;
            end
            MODE_EIGHT:
            begin
                px = round_shift_q(r * sine_of_turn(doubled), 15);
                py = round_shift_q(r * cosine_of_turn(ang), 14);
                pz = fixed_z;
            end
            MODE_INCLINED:
            begin
                rc = r * cosine_of_turn(ang);
                px = round_shift_q(rc * COS_PI6_Q14, 28);
                py = round_shift_q(r * sine_of_turn(ang), 14);
                pz = round_shift_q(rc, 15);
            end
            default:
            begin
                // no path selected: coordinates stay at zero
            end
        endcase
        pos  = count;
        span = run_length;
        pt.x          = clamp_coord(px);
        pt.y          = clamp_coord(py);
        pt.z          = clamp_coord(pz);
        pt.number     = count;
        pt.end_of_run = (pos + 1 >= span);
        if (pt.end_of_run)
        begin
            count = '0;
            phase = '0;
        end
        else
        begin
            count = count + 16'd1;
            phase = phase + step_size;
        end
        return pt;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("waypoint mismatch at %0t: %s got %0d expected %0d",
                     $time, what, got, want);
    endtask

    // Fill the quarter-wave table once
    initial
    begin : build_sine
        int unsigned k;
        for (k = 0; k <= TABLE_DEPTH; k++)
            quarter_sine[k] = series_sine_q14((64'(k) * HALF_PI_Q30) / TABLE_DEPTH);
    end

    // Track register writes, predict on each input transfer, compare on each output transfer
    always @(posedge clk or negedge rst_n)
    begin : watch
        waypoint_t want;
        if (!rst_n)
        begin
            path_mode   = RST_MODE;
            step_size   = RST_PHASE_STEP;
            run_length  = RST_TOTAL_POINTS;
            path_radius = RST_RADIUS;
            fixed_x     = '0;
            fixed_z     = '0;
            phase       = '0;
            count       = '0;
            expected_points.delete();
            waiting    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODE:         path_mode   = cfg_data[2:0];
                    CFG_PHASE_STEP:   step_size   = cfg_data;
                    CFG_TOTAL_POINTS: run_length  = cfg_data;
                    CFG_RADIUS:       path_radius = cfg_data[14:0];
                    CFG_START_X:      fixed_x     = cfg_data;
                    CFG_START_Z:      fixed_z     = cfg_data;
                    default:          ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_points.size() == 0)
                    report_mismatch("waypoint with no request outstanding, point_number",
                                    point_number, 0);
                else
                begin
                    want = expected_points.pop_front();
                    if (pos_x !== want.x)
                        report_mismatch("pos_x", pos_x, want.x);
                    if (pos_y !== want.y)
                        report_mismatch("pos_y", pos_y, want.y);
                    if (pos_z !== want.z)
                        report_mismatch("pos_z", pos_z, want.z);
                    if (point_number !== want.number)
                        report_mismatch("point_number", point_number, want.number);
                    if (last !== want.end_of_run)
                        report_mismatch("last", last, want.end_of_run);
                end
            end
            if (in_valid && in_ready)
                expected_points.insert(expected_points.size(), next_waypoint(restart));
            waiting    <= expected_points.size();
            mismatches <= fail_count;
        end
    end

endmodule

[tb/tb.sv]
// Top of the trajectory generator testbench: clock, reset, stimulus and verdict.
module tb;
    import ptg_pkg::*;

    localparam int unsigned RANDOM_ITEMS  = 1250;
    // margin for the back end to finish its last point plus the output register
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned LONG_HOLD     = 400;
    localparam logic [2:0]  MODE_NONE     = 3'd5;
    localparam logic [2:0]  MODE_SPARE    = 3'd7;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               restart   = 1'b0;
    logic               out_ready = 1'b0;
    logic               in_ready;
    logic               out_valid;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]        point_number;
    logic               last;
    int unsigned        mismatches;
    int unsigned        waiting;

    int unsigned        send_idle_pct = 0;
    int unsigned        stall_pct     = 0;
    bit                 hold_request  = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    parametric_trajectory_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .point_number (point_number),
        .last         (last)
    );

    waypoint_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .point_number (point_number),
        .last         (last),
        .mismatches   (mismatches),
        .waiting      (waiting)
    );

    // Receiver: random stalls, or one long hold-off on request
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Hard stop in case the block hangs
    initial
    begin : watchdog
        #3000000;
        $display("parametric_trajectory_generator verification failed");
        $finish;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [2:0] m, input logic [15:0] step,
                             input logic [15:0] total, input logic [14:0] rad,
                             input logic [15:0] sx, input logic [15:0] sz);
        write_reg(CFG_MODE, {13'b0, m});
        write_reg(CFG_PHASE_STEP, step);
        write_reg(CFG_TOTAL_POINTS, total);
        write_reg(CFG_RADIUS, {1'b0, rad});
        write_reg(CFG_START_X, sx);
        write_reg(CFG_START_Z, sz);
    endtask

    // Offer one request, idling first at the current rate; return on its transfer
    task automatic offer_point(input logic from_start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= from_start;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every waypoint has come out and the back end is idle
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Directed check of one path setting: restart, then follow the run
    task automatic probe_path(input logic [2:0] m, input logic [15:0] step,
                              input logic [15:0] total, input logic [14:0] rad,
                              input logic [15:0] sx, input logic [15:0] sz,
                              input int unsigned points);
        int unsigned i;
        settle();
        configure(m, step, total, rad, sx, sz);
        for (i = 0; i < points; i++)
            offer_point(i == 0);
    endtask

    // Pick a random register setting, extremes weighted up
    task automatic shuffle_config();
        logic [2:0]  m;
        logic [15:0] step;
        logic [15:0] total;
        logic [14:0] rad;
        logic [15:0] sx;
        logic [15:0] sz;
        if ($urandom_range(9) == 0)
            m = 3'($urandom_range(MODE_NONE, MODE_SPARE));
        else
            m = 3'($urandom_range(MODE_HORIZONTAL, MODE_INCLINED));
        case ($urandom_range(7))
            0:       step = '0;
            1:       step = 16'd1;
            2:       step = 16'h8000;
            3:       step = 16'hFFFF;
            default: step = 16'($urandom);
        endcase
        case ($urandom_range(7))
            0:       total = '0;
            1:       total = 16'hFFFF;
            2:       total = 16'($urandom);
            default: total = 16'($urandom_range(1, 40));
        endcase
        case ($urandom_range(5))
            0:       rad = '0;
            1:       rad = 15'd16384;
            2:       rad = 15'h7FFF;
            default: rad = 15'($urandom_range(0, 16384));
        endcase
        case ($urandom_range(3))
            0:       sx = 16'h8000;
            1:       sx = 16'h7FFF;
            default: sx = 16'($urandom);
        endcase
        case ($urandom_range(3))
            0:       sz = 16'h7FFF;
            1:       sz = 16'h8000;
            default: sz = 16'($urandom);
        endcase
        configure(m, step, total, rad, sx, sz);
    endtask

    initial
    begin : stimulus
        int unsigned random_sent;
        int unsigned group;
        int unsigned burst;
        int unsigned i;
        random_sent = 0;
        group       = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings, then each path at full radius and around the extremes
        offer_point(1'b0);
        offer_point(1'b0);
        probe_path(MODE_HORIZONTAL, 16'h2000, 16'd3, 15'd16384, 16'h8000, 16'h7FFF, 4);
        probe_path(MODE_VERTICAL, 16'h4000, 16'd2, 15'd16384, 16'h8000, 16'h7FFF, 3);
        probe_path(MODE_LISSAJOUS, 16'h2000, 16'd8, 15'h7FFF, 16'h7FFF, 16'h8000, 3);
        probe_path(MODE_EIGHT, 16'h2000, 16'd8, 15'd16384, 16'h7FFF, 16'h8000, 3);
        probe_path(MODE_INCLINED, 16'hFFFF, 16'hFFFF, 15'h7FFF, 16'h8000, 16'h7FFF, 3);
        probe_path(MODE_NONE, 16'h8000, 16'd2, 15'd16384, 16'h7FFF, 16'h8000, 2);
        probe_path(MODE_SPARE, 16'd1, 16'd1, 15'd0, 16'h8000, 16'h8000, 1);
        // zero run length and zero phase step
        probe_path(MODE_HORIZONTAL, 16'd0, 16'd0, 15'd1966, 16'd0, 16'd0, 2);
        probe_path(MODE_INCLINED, 16'h8000, 16'd5, 15'd16384, 16'h7FFF, 16'h7FFF, 2);

        // Random runs, rotating through the idling plans
        while (random_sent < RANDOM_ITEMS)
        begin
            settle();
            shuffle_config();
            case (group % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 88; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 88; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            burst = $urandom_range(10, 60);
            // hold the output off while requests keep coming, so the input backs up
            if (group == 4)
            begin
                burst        = 30;
                hold_request = 1'b1;
            end
            for (i = 0; i < burst; i++)
                offer_point($urandom_range(99) < 6);
            random_sent += burst;
            group++;
        end
        settle();

        if (mismatches == 0 && waiting == 0)
            $display("parametric_trajectory_generator verification clean");
        else
            $display("parametric_trajectory_generator verification failed");
        $finish;
    end

endmodule
